### hw/rtl/assert_macros.svh
// Assertion macros shared by the timer wheel RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

### hw/rtl/stw_pkg.sv
// Shared types and constants for the single-level timer wheel
package stw_pkg;
	localparam int WHEEL_SLOTS = 256;
	localparam int NUM_TIMERS  = 32;
	localparam int SW = $clog2(WHEEL_SLOTS);
	localparam int TW = $clog2(NUM_TIMERS);
	localparam int LW = TW + 1;
	localparam logic [LW-1:0] LINK_NONE = LW'(NUM_TIMERS);
	localparam logic [1:0] OP_ARM = 2'd0;
	localparam logic [1:0] OP_MOD = 2'd1;
	localparam logic [1:0] OP_DEL = 2'd2;
	localparam logic [1:0] OP_RUN = 2'd3;
	localparam logic [1:0] KIND_ACK   = 2'd0;
	localparam logic [1:0] KIND_FIRED = 2'd1;
	localparam logic [1:0] KIND_NONE  = 2'd2;

	typedef enum logic [3:0] {
		DP_NOP    = 4'd0,
		DP_LOAD   = 4'd1,
		DP_RD_NBR = 4'd2,
		DP_UNLINK = 4'd3,
		DP_RD_SLT = 4'd4,
		DP_LINK   = 4'd5,
		DP_RUN_RD = 4'd6,
		DP_HEAD   = 4'd7,
		DP_FIRE   = 4'd8,
		DP_NEXT   = 4'd9
	} dp_cmd_t;

	typedef struct packed {
		logic       id_ok;
		logic       pending;
		logic       same_exp;
		logic       run_past;
		logic       cur_none;
		logic       run_done;
	} dp_stat_t;
endpackage

### hw/rtl/stw_datapath.sv
// Datapath: slot lists, timer tables and run walker
`include "assert_macros.svh"
module stw_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  stw_pkg::dp_cmd_t          cmd,
	input  logic                      cfg_we,
	input  logic [31:0]               cfg_wdata,
	input  logic [4:0]                in_id,
	input  logic [31:0]               in_exp,
	input  logic [31:0]               in_now,
	output stw_pkg::dp_stat_t         stat,
	output logic [4:0]                cur_id
);
	import stw_pkg::*;

	logic [31:0]       tick_q;
	logic [TW-1:0]     id_q;
	logic              id_ok_q;
	logic [31:0]       exp_q, now_q;
	logic [LW-1:0]     head_mem [WHEEL_SLOTS];
	logic [TW-1:0]     tail_mem [WHEEL_SLOTS];
	logic [WHEEL_SLOTS-1:0] head_ok_q;
	logic [LW-1:0]     next_q [NUM_TIMERS];
	logic [LW-1:0]     prev_q [NUM_TIMERS];
	logic [SW-1:0]     tslot_q [NUM_TIMERS];
	logic [31:0]       texp_q [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] pend_q;
	logic [LW-1:0]     p_q, n_q, head_rd_q;
	logic [TW-1:0]     tail_rd_q;
	logic [SW-1:0]     slot_q;
	logic [SW:0]       walk_q, walk_max_q;
	logic [LW-1:0]     cur_q;
	logic [31:0]       d_exp, d_now;
	logic [SW-1:0]     new_slot, run_slot, next_run_slot;
	logic [LW-1:0]     head_v;
	logic              walk_last;

	assign d_exp = exp_q - tick_q;
	assign d_now = now_q - tick_q;
	assign head_v = head_ok_q[slot_q] ? head_rd_q : LINK_NONE;
	assign walk_last = (walk_q + (SW+1)'(1)) == walk_max_q;

	always_comb begin
		if (d_exp < 32'(WHEEL_SLOTS))
			new_slot = SW'(exp_q % WHEEL_SLOTS);
		else if (d_exp[31])
			new_slot = SW'(tick_q % WHEEL_SLOTS);
		else
			new_slot = SW'((tick_q + 32'(WHEEL_SLOTS - 1)) % WHEEL_SLOTS);
	end
	assign run_slot = SW'((tick_q + 32'(walk_q)) % WHEEL_SLOTS);
	assign next_run_slot = SW'((tick_q + 32'(walk_q) + 32'd1) % WHEEL_SLOTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q    <= '0;
			head_ok_q <= '0;
			pend_q    <= '0;
			walk_q    <= '0;
		end else if (cfg_we) begin
			tick_q    <= cfg_wdata;
			head_ok_q <= '0;
			pend_q    <= '0;
		end else begin
			unique case (cmd)
				DP_LOAD: begin
					id_q     <= TW'(in_id);
					id_ok_q  <= 32'(in_id) < 32'(NUM_TIMERS);
					exp_q    <= in_exp;
					now_q    <= in_now;
					walk_q   <= '0;
				end
				DP_RD_NBR: begin
					p_q <= prev_q[id_q];
					n_q <= next_q[id_q];
					slot_q <= tslot_q[id_q];
				end
				DP_UNLINK: begin
					if (p_q == LINK_NONE) begin
						head_ok_q[slot_q] <= 1'b1;
					end else
						next_q[TW'(p_q)] <= n_q;
					if (n_q != LINK_NONE)
						prev_q[TW'(n_q)] <= p_q;
					pend_q[id_q] <= 1'b0;
				end
				DP_RD_SLT: slot_q <= new_slot;
				DP_LINK: begin
					texp_q[id_q]  <= exp_q;
					tslot_q[id_q] <= slot_q;
					next_q[id_q]  <= LINK_NONE;
					head_ok_q[slot_q] <= 1'b1;
					if (head_v == LINK_NONE)
						prev_q[id_q] <= LINK_NONE;
					else begin
						prev_q[id_q] <= LW'(tail_rd_q);
						next_q[tail_rd_q] <= LW'(id_q);
					end
					pend_q[id_q] <= 1'b1;
				end
				DP_RUN_RD: begin
					slot_q     <= run_slot;
					walk_max_q <= (d_now >= 32'(WHEEL_SLOTS)) ? (SW+1)'(WHEEL_SLOTS)
						: (SW+1)'(d_now + 32'd1);
				end
				DP_HEAD: cur_q <= head_v;
				DP_FIRE: begin
					pend_q[TW'(cur_q)] <= 1'b0;
					cur_q <= next_q[TW'(cur_q)];
				end
				DP_NEXT: begin
					head_ok_q[slot_q] <= 1'b1;
					walk_q <= walk_q + 1'b1;
					slot_q <= next_run_slot;
					if (walk_last)
						tick_q <= now_q + 32'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		head_rd_q <= head_mem[slot_q];
		tail_rd_q <= tail_mem[slot_q];
		if (cmd == DP_UNLINK && !cfg_we) begin
			if (p_q == LINK_NONE) head_mem[slot_q] <= n_q;
			if (n_q == LINK_NONE && p_q != LINK_NONE) tail_mem[slot_q] <= TW'(p_q);
		end else if (cmd == DP_LINK && !cfg_we) begin
			if (head_v == LINK_NONE) head_mem[slot_q] <= LW'(id_q);
			tail_mem[slot_q] <= id_q;
		end else if (cmd == DP_NEXT && !cfg_we)
			head_mem[slot_q] <= LINK_NONE;
	end

	assign stat.id_ok     = id_ok_q;
	assign stat.pending   = pend_q[id_q];
	assign stat.same_exp  = texp_q[id_q] == exp_q;
	assign stat.run_past  = d_now[31];
	assign stat.cur_none  = cur_q == LINK_NONE;
	assign stat.run_done  = walk_last;
	assign cur_id         = cur_q[TW-1:0];

	`ASSERT_NEVER(a_walk_ovf, clk, arst_n, walk_q > (SW+1)'(WHEEL_SLOTS), "walk past wheel")
	`ASSERT_CLK(a_walk, clk, arst_n, (cmd == DP_NEXT && !cfg_we) |=> walk_q != '0, "walk did not advance")
	`ASSERT_CLK(a_link_pend, clk, arst_n, (cmd == DP_LINK && !cfg_we) |=> pend_q[id_q], "link lost")
endmodule

### hw/rtl/stw_ctrl.sv
// Controller: sequences operations and drives the result register
`include "assert_macros.svh"
module stw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         in_op,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         kind,
	output logic               was_pending,
	output logic [4:0]         fired_id,
	output logic               last,
	input  stw_pkg::dp_stat_t  stat,
	input  logic [4:0]         cur_id,
	output stw_pkg::dp_cmd_t   cmd
);
	import stw_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_DEC  = 10'b0000000010,
		S_NBR  = 10'b0000000100,
		S_UNL  = 10'b0000001000,
		S_SLT  = 10'b0000010000,
		S_LNK  = 10'b0000100000,
		S_RHD  = 10'b0001000000,
		S_HD   = 10'b0010000000,
		S_FIRE = 10'b0100000000,
		S_ACK  = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic [1:0] op_q;
	logic wp_q, stage_vld_q;
	logic [4:0] stage_id_q;
	logic emit;
	logic [1:0] e_kind;
	logic e_wp, e_last;
	logic [4:0] e_id;

	assign in_ready = state_q == S_IDLE && !out_valid;

	always_comb begin
		state_d = state_q;
		cmd = DP_NOP;
		emit = 1'b0;
		e_kind = KIND_ACK; e_wp = 1'b0; e_id = '0; e_last = 1'b0;
		unique case (state_q)
			S_IDLE: if (in_valid && in_ready) begin
				cmd = DP_LOAD; state_d = S_DEC;
			end
			S_DEC: begin
				if (op_q == OP_RUN) begin
					if (stat.run_past) state_d = S_ACK;
					else begin cmd = DP_RUN_RD; state_d = S_RHD; end
				end else if (!stat.id_ok) state_d = S_ACK;
				else if (op_q == OP_ARM && stat.pending && stat.same_exp) state_d = S_ACK;
				else if (stat.pending) begin cmd = DP_RD_NBR; state_d = S_NBR; end
				else if (op_q == OP_ARM) begin cmd = DP_RD_SLT; state_d = S_SLT; end
				else state_d = S_ACK;
			end
			S_NBR: begin cmd = DP_UNLINK; state_d = S_UNL; end
			S_UNL: begin
				if (op_q == OP_DEL) state_d = S_ACK;
				else begin cmd = DP_RD_SLT; state_d = S_SLT; end
			end
			S_SLT: state_d = S_LNK;
			S_LNK: begin cmd = DP_LINK; state_d = S_ACK; end
			S_RHD: state_d = S_HD;
			S_HD: begin cmd = DP_HEAD; state_d = S_FIRE; end
			S_FIRE: begin
				if (stat.cur_none) begin
					cmd = DP_NEXT;
					state_d = stat.run_done ? S_ACK : S_RHD;
				end else if (!stage_vld_q || !out_valid || out_ready) begin
					cmd = DP_FIRE;
					emit = stage_vld_q; e_kind = KIND_FIRED; e_id = stage_id_q;
				end
			end
			S_ACK: if (!out_valid || out_ready) begin
				emit = 1'b1; e_last = 1'b1; state_d = S_IDLE;
				if (op_q == OP_RUN) begin
					if (stage_vld_q) begin e_kind = KIND_FIRED; e_id = stage_id_q; end
					else e_kind = KIND_NONE;
				end else e_wp = wp_q;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; out_valid <= 1'b0; op_q <= OP_ARM;
			wp_q <= 1'b0; stage_vld_q <= 1'b0; stage_id_q <= '0;
		end else begin
			state_q <= state_d;
			if (emit) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (cmd == DP_LOAD) begin
				op_q <= in_op;
				stage_vld_q <= 1'b0;
			end
			if (state_q == S_DEC) wp_q <= stat.id_ok && stat.pending;
			if (cmd == DP_FIRE) begin
				stage_vld_q <= 1'b1;
				stage_id_q <= cur_id;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind <= e_kind; was_pending <= e_wp; fired_id <= e_id; last <= e_last;
		end
	end

	`ASSERT_CLK(a_ready_idle, clk, arst_n, in_ready |-> state_q == S_IDLE, "ready outside idle")
	`ASSERT_NEVER(a_emit_hold, clk, arst_n, emit && out_valid && !out_ready, "result overwritten")
	`ASSERT_CLK(a_onehot, clk, arst_n, $onehot(state_q), "state not one-hot")
endmodule

### hw/rtl/single_level_timer_wheel.sv
// Top level of the single-level timer wheel
// channel  | handshake               | payload
// in       | in_valid / in_ready     | operation, timer_id, expiry, now_tick
// out      | out_valid / out_ready   | kind, was_pending, fired_id, last
// cfg      | cfg_we                  | cfg_wdata (start_tick)
// Arm, modify and delete decode, then read neighbours and unlink, read the slot and
// link, or do both, as the timer needs. Run decodes, then for each visited slot reads
// the slot, takes its head and fires its timers one by one, then closes with a result.
// The next transaction is accepted once the final result has left the output register.
// Reset and start_tick writes empty the wheel at once through slot valid bits.
// A stalled result holds the controller before the next fire or final result, but a run still moves past emptied slots.
module single_level_timer_wheel (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [4:0]  timer_id,
	input  logic [31:0] expiry,
	input  logic [31:0] now_tick,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic        was_pending,
	output logic [4:0]  fired_id,
	output logic        last,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);
	import stw_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic [4:0] cur_id;

	stw_datapath u_dp (
		.clk, .arst_n, .cmd, .cfg_we, .cfg_wdata,
		.in_id(timer_id), .in_exp(expiry), .in_now(now_tick),
		.stat, .cur_id
	);

	stw_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .in_op(operation),
		.out_valid, .out_ready, .kind, .was_pending, .fired_id, .last,
		.stat, .cur_id, .cmd
	);
endmodule
